// ===== hw/rtl/bc_pkg.sv =====
// ----------------------------------------------------------------------------
// bc_pkg
// Shared widths, controller states and the command/status words that join
// the binomial coefficient controller and datapath.
// ----------------------------------------------------------------------------
package bc_pkg;

   localparam int N_W     = 6;   // width of n and k
   localparam int VALUE_W = 30;  // width of the result
   localparam int ACC_W   = 40;  // accumulator width
   localparam int DIV_W   = 6;   // divisor and remainder width
   localparam int CNT_W   = 6;   // quotient bit counter, 0 .. ACC_W-1

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } bc_state_type;

   typedef struct packed {
      logic load;      // capture n and k, set up the iteration
      logic mul;       // multiply accumulator by the multiplier
      logic div_step;  // one restoring division step
      logic emit;      // move the accumulator to the result register
   } bc_cmd_type;

   typedef struct packed {
      logic iter_zero; // no iterations left
      logic div_last;  // current division step produces the last quotient bit
   } bc_status_type;

endpackage

// ===== hw/rtl/bc_req_if.sv =====
// ----------------------------------------------------------------------------
// bc_req_if
// Request channel: one word carries n and k.
// ----------------------------------------------------------------------------
interface bc_req_if;

   logic                   valid;
   logic                   ready;
   logic [bc_pkg::N_W-1:0] n;
   logic [bc_pkg::N_W-1:0] k;

   modport source (output valid, output n, output k, input ready);
   modport sink   (input valid, input n, input k, output ready);

endinterface

// ===== hw/rtl/bc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bc_rsp_if
// Response channel: one word carries the binomial coefficient.
// ----------------------------------------------------------------------------
interface bc_rsp_if;

   logic                       valid;
   logic                       ready;
   logic [bc_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

// ===== hw/rtl/bc_datapath.sv =====
// ----------------------------------------------------------------------------
// bc_datapath
// Accumulator, multiplier/divisor counters and a one-bit-per-cycle restoring
// divider, driven by commands from the controller.
// ----------------------------------------------------------------------------
module bc_datapath #(
   parameter int MAX_N = 32
) (
   input  logic                       clock,
   input  logic [bc_pkg::N_W-1:0]     n,
   input  logic [bc_pkg::N_W-1:0]     k,
   input  bc_pkg::bc_cmd_type         cmd,
   output bc_pkg::bc_status_type      status,
   output logic [bc_pkg::VALUE_W-1:0] value
);

   localparam int PROD_W = bc_pkg::ACC_W + bc_pkg::N_W;

   logic [bc_pkg::ACC_W-1:0]   acc_ff,   acc_in;
   logic [bc_pkg::N_W-1:0]     mult_ff,  mult_in;
   logic [bc_pkg::DIV_W-1:0]   div_ff,   div_in;
   logic [bc_pkg::N_W-1:0]     iter_ff,  iter_in;
   logic [bc_pkg::DIV_W-1:0]   rem_ff,   rem_in;
   logic [bc_pkg::CNT_W-1:0]   cnt_ff,   cnt_in;
   logic [bc_pkg::VALUE_W-1:0] value_ff, value_in;

   logic [bc_pkg::N_W:0]     max_n;
   logic                     k_gt_n;
   logic                     n_sat;
   logic [bc_pkg::N_W-1:0]   k_sel;
   logic [PROD_W-1:0]        product;
   logic [bc_pkg::DIV_W:0]   rem_sh;
   logic [bc_pkg::DIV_W:0]   rem_diff;
   logic                     q_bit;
   logic                     div_last;

   always_comb begin
      max_n    = (bc_pkg::N_W+1)'(MAX_N);
      k_gt_n   = k > n;
      n_sat    = {1'b0, n} > max_n;
      // mirror k to the smaller half
      k_sel    = (k > (n >> 1)) ? (n - k) : k;
      product  = PROD_W'(acc_ff) * PROD_W'(mult_ff);
      rem_sh   = {rem_ff, acc_ff[bc_pkg::ACC_W-1]};
      rem_diff = rem_sh - {1'b0, div_ff};
      q_bit    = rem_sh >= {1'b0, div_ff};
      div_last = cnt_ff == bc_pkg::CNT_W'(bc_pkg::ACC_W - 1);

      acc_in   = acc_ff;
      mult_in  = mult_ff;
      div_in   = div_ff;
      iter_in  = iter_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      value_in = value_ff;

      if (cmd.load) begin
         mult_in = n;
         div_in  = bc_pkg::DIV_W'(1);
         if (k_gt_n) begin
            acc_in  = '0;
            iter_in = '0;
         end else if (n_sat) begin
            acc_in  = {{(bc_pkg::ACC_W-bc_pkg::VALUE_W){1'b0}}, {bc_pkg::VALUE_W{1'b1}}};
            iter_in = '0;
         end else begin
            acc_in  = bc_pkg::ACC_W'(1);
            iter_in = k_sel;
         end
      end

      if (cmd.mul) begin
         acc_in = product[bc_pkg::ACC_W-1:0];
         rem_in = '0;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         // shift dividend into remainder, quotient bit back into the accumulator
         rem_in = q_bit ? rem_diff[bc_pkg::DIV_W-1:0] : rem_sh[bc_pkg::DIV_W-1:0];
         acc_in = {acc_ff[bc_pkg::ACC_W-2:0], q_bit};
         cnt_in = cnt_ff + bc_pkg::CNT_W'(1);
         if (div_last) begin
            mult_in = mult_ff - bc_pkg::N_W'(1);
            div_in  = div_ff + bc_pkg::DIV_W'(1);
            iter_in = iter_ff - bc_pkg::N_W'(1);
         end
      end

      if (cmd.emit) begin
         value_in = acc_ff[bc_pkg::VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mult_ff  <= mult_in;
      div_ff   <= div_in;
      iter_ff  <= iter_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      value_ff <= value_in;
   end

   assign status.iter_zero = iter_ff == '0;
   assign status.div_last  = div_last;
   assign value            = value_ff;

endmodule

// ===== hw/rtl/bc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bc_ctrl
// Sequencer for the binomial coefficient datapath: setup, then per iteration
// one multiply and a full restoring division, then hand-off to the result
// register.
// ----------------------------------------------------------------------------
module bc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_ready,
   input  bc_pkg::bc_status_type status,
   output bc_pkg::bc_cmd_type    cmd,
   output logic                  req_ready,
   output logic                  rsp_valid
);

   bc_pkg::bc_state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         bc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = bc_pkg::ST_CHECK;
            end
         end
         bc_pkg::ST_CHECK: begin
            state_in = status.iter_zero ? bc_pkg::ST_FINISH : bc_pkg::ST_MUL;
         end
         bc_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = bc_pkg::ST_DIV;
         end
         bc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = bc_pkg::ST_CHECK;
            end
         end
         bc_pkg::ST_FINISH: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/binomial_coefficient_core.sv =====
// ----------------------------------------------------------------------------
// binomial_coefficient_core
// Computes C(n,k) with a multiply / exact-divide iteration on a 40-bit
// accumulator.
// ----------------------------------------------------------------------------
// One request word (n, k) gives one response word C(n,k); k above n gives 0,
// n above MAX_N (with k not above n) gives all ones. After k is mirrored to
// min(k, n-k) (k up to 16), each word runs an iteration check, then per
// iteration a multiply and a one-bit-per-cycle restoring divider followed by
// the next check, then a finish step into the result register. One word is in
// work at a time; the next is accepted as soon as the previous result sits in
// the output register, even if not yet taken.
module binomial_coefficient_core #(
   parameter int MAX_N = 32
) (
   input  logic     clock,
   input  logic     reset,
   bc_req_if.sink   req,
   bc_rsp_if.source rsp
);

   bc_pkg::bc_cmd_type    cmd;
   bc_pkg::bc_status_type status;

   bc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid)
   );

   bc_datapath #(
      .MAX_N (MAX_N)
   ) u_datapath (
      .clock  (clock),
      .n      (req.n),
      .k      (req.k),
      .cmd    (cmd),
      .status (status),
      .value  (rsp.value)
   );

   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req.valid && req.ready))
      else $error("load issued without an accepted request word");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul, cmd.div_step, cmd.emit}))
      else $error("more than one datapath command at once");

   a_mul_then_div: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> cmd.div_step)
      else $error("multiply not followed by a division step");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp.valid)
      else $error("result emitted but response not valid");

endmodule

// ===== tb/tb_binomial_coefficient_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binomial_coefficient_core
// Self-checking bench for the binomial coefficient core. A table of directed
// (n, k) words covers the field extremes, the zero, unit and saturated cases
// and the mirrored-k path. Random words follow, each checked in order against
// a 40-bit multiply / exact-divide predictor. Both channels stall at random,
// except during one quiet stretch.
// ----------------------------------------------------------------------------
module tb_binomial_coefficient_core;

   localparam int MAX_N        = 32;
   localparam int RANDOM_WORDS = 530;
   localparam int IDLE_PCT     = 30;
   localparam int DRAIN_CYCLES = 700;
   localparam logic [bc_pkg::VALUE_W-1:0] SATURATED = '1;

   typedef struct {
      logic [bc_pkg::N_W-1:0]     n;
      logic [bc_pkg::N_W-1:0]     k;
      bit                         known;
      logic [bc_pkg::VALUE_W-1:0] value;
   } choose_row_type;

   typedef struct {
      logic [bc_pkg::N_W-1:0]     n;
      logic [bc_pkg::N_W-1:0]     k;
      logic [bc_pkg::VALUE_W-1:0] value;
   } choose_word_type;

   // expected value typed in where it is obvious, else computed by binom_value
   choose_row_type directed_rows [21] = '{
      '{6'd0,  6'd0,  1'b1, 30'd1},
      '{6'd32, 6'd16, 1'b1, 30'd601080390},
      '{6'd32, 6'd0,  1'b1, 30'd1},
      '{6'd32, 6'd32, 1'b1, 30'd1},
      '{6'd0,  6'd63, 1'b1, 30'd0},
      '{6'd63, 6'd63, 1'b1, SATURATED},
      '{6'd63, 6'd0,  1'b1, SATURATED},
      '{6'd33, 6'd1,  1'b1, SATURATED},
      '{6'd33, 6'd33, 1'b1, SATURATED},
      '{6'd42, 6'd21, 1'b1, SATURATED},
      '{6'd21, 6'd42, 1'b1, 30'd0},
      '{6'd5,  6'd6,  1'b1, 30'd0},
      '{6'd31, 6'd32, 1'b1, 30'd0},
      '{6'd32, 6'd33, 1'b1, 30'd0},
      '{6'd1,  6'd1,  1'b1, 30'd1},
      '{6'd7,  6'd1,  1'b1, 30'd7},
      '{6'd10, 6'd3,  1'b0, 30'd0},
      '{6'd20, 6'd10, 1'b0, 30'd0},
      '{6'd32, 6'd17, 1'b0, 30'd0},
      '{6'd32, 6'd31, 1'b0, 30'd0},
      '{6'd31, 6'd15, 1'b0, 30'd0}
   };

   logic clock;
   logic reset;

   bc_req_if req_if ();
   bc_rsp_if rsp_if ();

   binomial_coefficient_core #(
      .MAX_N(MAX_N)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   choose_word_type pending_values [$];
   bit              quiet;
   int              errors;
   int              words_sent;
   int              values_checked;
   int              zero_words;
   int              saturated_words;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("%0t: timeout with %0d results outstanding", $realtime,
               pending_values.size());
      $display("[binomial_coefficient_core] ERROR");
      $finish;
   end

   // C(n,k) on a 40-bit accumulator: multiply, then divide exactly
   function automatic logic [bc_pkg::VALUE_W-1:0] binom_value(
         input logic [bc_pkg::N_W-1:0] n,
         input logic [bc_pkg::N_W-1:0] k);
      logic [bc_pkg::ACC_W-1:0] acc;
      logic [63:0]              prod;
      int unsigned              mult;
      int unsigned              steps;
      int unsigned              divisor;
      if (k > n) return '0;
      if (n > MAX_N) return SATURATED;
      steps = (k > n / 2) ? 32'(n - k) : 32'(k);
      acc   = bc_pkg::ACC_W'(1);
      mult  = 32'(n);
      for (divisor = 1; divisor <= steps; divisor++) begin
         prod = {{(64 - bc_pkg::ACC_W){1'b0}}, acc} * 64'(mult);
         acc  = prod[bc_pkg::ACC_W-1:0] / bc_pkg::ACC_W'(divisor);
         mult--;
      end
      return acc[bc_pkg::VALUE_W-1:0];
   endfunction

   task automatic send_word(input logic [bc_pkg::N_W-1:0] n,
                            input logic [bc_pkg::N_W-1:0] k,
                            input logic [bc_pkg::VALUE_W-1:0] want);
      choose_word_type word;
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.n     <= n;
      req_if.k     <= k;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      word.n = n;
      word.k = k;
      word.value = want;
      pending_values = {pending_values, word};
      words_sent++;
      if (want == '0) zero_words++;
      if (want == SATURATED) saturated_words++;
   endtask

   // response side: check on handshake, then choose next ready
   always @(posedge clock) begin
      choose_word_type word;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_values.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %0d",
                        $realtime, rsp_if.value);
               errors++;
            end else begin
               word = pending_values.pop_front();
               values_checked++;
               if (rsp_if.value !== word.value) begin
                  $display("%0t: C(%0d,%0d) expected %0d, got %0d", $realtime,
                           word.n, word.k, word.value, rsp_if.value);
                  errors++;
               end
            end
         end
         rsp_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      int                         sel;
      int                         n_pick;
      int                         k_pick;
      int                         drain;
      logic [bc_pkg::VALUE_W-1:0] want;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.n     <= '0;
      req_if.k     <= '0;
      quiet  = 1'b0;
      errors = 0;
      words_sent      = 0;
      values_checked  = 0;
      zero_words      = 0;
      saturated_words = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         want = directed_rows[i].known ? directed_rows[i].value
                : binom_value(directed_rows[i].n, directed_rows[i].k);
         send_word(directed_rows[i].n, directed_rows[i].k, want);
      end

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         // keep both sides free of stalls for one stretch of words
         quiet = (i >= 250 && i < 350);
         sel = $urandom_range(0, 99);
         if (sel < 80) begin
            n_pick = $urandom_range(0, MAX_N);
            k_pick = $urandom_range(0, n_pick);
         end else if (sel < 90) begin
            n_pick = $urandom_range(0, 62);
            k_pick = $urandom_range(n_pick + 1, 63);
         end else begin
            n_pick = $urandom_range(MAX_N + 1, 63);
            k_pick = $urandom_range(0, 63);
         end
         want = binom_value(bc_pkg::N_W'(n_pick), bc_pkg::N_W'(k_pick));
         send_word(bc_pkg::N_W'(n_pick), bc_pkg::N_W'(k_pick), want);
      end
      quiet = 1'b0;
      req_if.valid <= 1'b0;

      while (pending_values.size() != 0) @(posedge clock);
      for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clock);

      $display("Sent %0d words (%0d zero, %0d saturated); %0d results checked.",
               words_sent, zero_words, saturated_words, values_checked);
      $display("Mismatches and unexpected results: %0d", errors);
      if (errors == 0) begin
         $display("[binomial_coefficient_core] OK");
      end else begin
         $display("[binomial_coefficient_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== binomial_coefficient_core.f =====
hw/rtl/bc_pkg.sv
hw/rtl/bc_req_if.sv
hw/rtl/bc_rsp_if.sv
hw/rtl/bc_datapath.sv
hw/rtl/bc_ctrl.sv
hw/rtl/binomial_coefficient_core.sv
tb/tb_binomial_coefficient_core.sv
